FILE: rtl/core/smic_pkg.sv
// ----------------------------------------------------------------------------
// smic_pkg
// Shared types and codes of the shadow memory init checker.
// ----------------------------------------------------------------------------
package smic_pkg;

	localparam int ADDR_W     = 32;
	localparam int IP_W       = 32;
	localparam int COUNT_W    = 13;
	localparam int STATE_W    = 2;
	localparam int SIZE_W     = 2;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	// error record: {state, address, size code}
	localparam int REC_W      = STATE_W + ADDR_W + SIZE_W;

	localparam logic [MODE_W-1:0] MODE_MARK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd3;

	localparam logic [STATE_W-1:0] ST_UNALLOC = 2'd0;
	localparam logic [STATE_W-1:0] ST_INIT    = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_BAD = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_OK  = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_OFFSET,
		S_FIT,
		S_DISPATCH,
		S_RD_REQ,
		S_RD_CHK,
		S_FILL,
		S_LOG,
		S_FINISH
	} smic_state_t;

	typedef struct packed {
		logic load_in;
		logic calc_off;
		logic calc_fit;
		logic clr_wr;
		logic sh_rd;
		logic cap_found;
		logic run_wr;
		logic pos_dec;
		logic pos_inc;
		logic pos_lo;
		logic log_err;
		logic drain_rd;
		logic out_load;
	} smic_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              fits;
		logic              pos_zero;
		logic              pos_last;
		logic              clr_done;
		logic              hit;
		logic              rd_init;
		logic              out_free;
	} smic_sts_t;

endpackage

FILE: rtl/core/smic_ram.sv
// ----------------------------------------------------------------------------
// smic_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module smic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/smic_ctrl.sv
// ----------------------------------------------------------------------------
// smic_ctrl
// Sequencer: shadow clear after reset, then one word at a time through
// window check, byte test, byte fill, error logging and result hand-off.
// ----------------------------------------------------------------------------
module smic_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  smic_pkg::smic_sts_t sts,
	output smic_pkg::smic_cmd_t cmd
);

	import smic_pkg::*;

	smic_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_OFFSET;
			end
			S_OFFSET:   state_d = S_FIT;
			S_FIT:      state_d = S_DISPATCH;
			S_DISPATCH: begin
				priority if (sts.mode == MODE_DRAIN) state_d = S_FINISH;
				else if (!sts.fits)                  state_d = S_FINISH;
				else if (sts.mode == MODE_READ)      state_d = S_RD_REQ;
				else                                 state_d = S_FILL;
			end
			S_RD_REQ: state_d = S_RD_CHK;
			S_RD_CHK: begin
				if (sts.hit || sts.pos_zero) begin
					state_d = sts.rd_init ? S_FINISH : S_FILL;
				end else begin
					state_d = S_RD_REQ;
				end
			end
			S_FILL: begin
				if (sts.pos_last) begin
					state_d = (sts.mode == MODE_READ) ? S_LOG : S_FINISH;
				end
			end
			S_LOG:    state_d = S_FINISH;
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default:  state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: cmd.clr_wr = 1'b1;
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			S_OFFSET:   cmd.calc_off = 1'b1;
			S_FIT:      cmd.calc_fit = 1'b1;
			S_DISPATCH: cmd.drain_rd = (sts.mode == MODE_DRAIN);
			S_RD_REQ:   cmd.sh_rd    = 1'b1;
			S_RD_CHK: begin
				cmd.cap_found = 1'b1;
				if (!(sts.hit || sts.pos_zero)) begin
					cmd.pos_dec = 1'b1;
				end else if (!sts.rd_init) begin
					cmd.pos_lo = 1'b1;
				end
			end
			S_FILL: begin
				cmd.run_wr  = 1'b1;
				cmd.pos_inc = !sts.pos_last;
			end
			S_LOG:    cmd.log_err  = 1'b1;
			S_FINISH: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/smic_dp.sv
// ----------------------------------------------------------------------------
// smic_dp
// Datapath: config registers, word registers, window arithmetic, shadow
// store, error ring with its pointers, and the result register.
// ----------------------------------------------------------------------------
module smic_dp #(
	parameter int WINDOW_BYTES = 4096,
	parameter int RING_DEPTH   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smic_pkg::smic_cmd_t                  cmd,
	output smic_pkg::smic_sts_t                  sts,
	input  logic                                 cfg_we,
	input  logic [smic_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smic_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [smic_pkg::MODE_W-1:0]          mode,
	input  logic [smic_pkg::ADDR_W-1:0]          address,
	input  logic [smic_pkg::SIZE_W-1:0]          size_code,
	input  logic [smic_pkg::COUNT_W-1:0]         count,
	input  logic [smic_pkg::STATE_W-1:0]         mark_state,
	input  logic [smic_pkg::IP_W-1:0]            ip,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [smic_pkg::STATE_W-1:0]         found_state,
	output logic                                 error_flag,
	output logic                                 error_logged,
	output logic                                 record_valid,
	output logic [smic_pkg::STATE_W-1:0]         record_state,
	output logic [smic_pkg::ADDR_W-1:0]          record_address,
	output logic [smic_pkg::SIZE_W-1:0]          record_size_code,
	output logic [$clog2(RING_DEPTH+1)-1:0]      queue_level
);

	import smic_pkg::*;

	localparam int SH_AW   = $clog2(WINDOW_BYTES);
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int FILL_W  = $clog2(RING_DEPTH + 1);

	logic [ADDR_W-1:0]  window_base_q;
	logic               partial_ok_q;

	logic [MODE_W-1:0]  mode_q;
	logic [ADDR_W-1:0]  address_q;
	logic [SIZE_W-1:0]  size_code_q;
	logic [COUNT_W-1:0] count_q;
	logic [STATE_W-1:0] mark_state_q;
	logic [IP_W-1:0]    ip_q;

	logic [ADDR_W-1:0]  offset_q;
	logic [COUNT_W-1:0] len_q;
	logic               fits_q;
	logic [COUNT_W-1:0] pos_q;
	logic [SH_AW-1:0]   clr_q;

	logic [STATE_W-1:0] found_q;
	logic               err_q;
	logic               logged_q;
	logic               rvalid_q;

	logic [RING_AW-1:0] rd_idx_q, wr_idx_q;
	logic [FILL_W-1:0]  fill_q;
	logic [IP_W-1:0]    last_ip_q;

	logic [ADDR_W-1:0]  run_sum;
	logic [SH_AW-1:0]   sh_addr;
	logic               sh_we;
	logic [STATE_W-1:0] sh_wdata;
	logic [STATE_W-1:0] sh_rdata;

	logic               new_ip;
	logic               ring_full;
	logic               ring_we;
	logic               ring_re;
	logic [REC_W-1:0]   ring_wdata;
	logic [REC_W-1:0]   ring_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= '0;
			partial_ok_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_BASE: window_base_q <= cfg_data;
				CFG_PARTIAL_OK:  partial_ok_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// word registers and per-item working state
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q       <= mode;
			address_q    <= address;
			size_code_q  <= size_code;
			count_q      <= count;
			mark_state_q <= mark_state;
			ip_q         <= ip;
			found_q      <= ST_INIT;
			err_q        <= 1'b0;
			logged_q     <= 1'b0;
		end
		if (cmd.calc_off) begin
			offset_q <= address_q - window_base_q;
			if (mode_q == MODE_MARK) begin
				len_q <= count_q;
			end else if (size_code_q == SIZE_BAD) begin
				len_q <= '0;
			end else begin
				len_q <= COUNT_W'(1) << size_code_q;
			end
		end
		if (cmd.calc_fit) begin
			fits_q <= (len_q != '0) &&
				(({1'b0, offset_q} + (ADDR_W + 1)'(len_q)) <= (ADDR_W + 1)'(WINDOW_BYTES));
			// reads test from the highest byte down, fills run upward
			pos_q  <= (mode_q == MODE_READ) ? len_q - COUNT_W'(1) : '0;
		end
		if (cmd.pos_dec) pos_q <= pos_q - COUNT_W'(1);
		if (cmd.pos_inc) pos_q <= pos_q + COUNT_W'(1);
		if (cmd.pos_lo)  pos_q <= '0;
		if (cmd.cap_found) found_q <= sh_rdata;
		if (cmd.log_err) begin
			err_q    <= 1'b1;
			logged_q <= ring_we;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + SH_AW'(1);
		end
	end

	// shadow store
	assign run_sum  = offset_q + ADDR_W'(pos_q);
	assign sh_addr  = cmd.clr_wr ? clr_q : run_sum[SH_AW-1:0];
	assign sh_we    = cmd.clr_wr || cmd.run_wr;
	assign sh_wdata = cmd.clr_wr ? ST_UNALLOC :
		((mode_q == MODE_MARK) ? mark_state_q : ST_INIT);

	smic_ram #(
		.WIDTH(STATE_W),
		.DEPTH(WINDOW_BYTES)
	) u_shadow (
		.clk  (clk),
		.we   (sh_we),
		.waddr(sh_addr),
		.wdata(sh_wdata),
		.re   (cmd.sh_rd),
		.raddr(sh_addr),
		.rdata(sh_rdata)
	);

	// error ring
	assign new_ip     = (ip_q != last_ip_q);
	assign ring_full  = (fill_q == FILL_W'(RING_DEPTH));
	assign ring_we    = cmd.log_err && new_ip && !ring_full;
	assign ring_re    = cmd.drain_rd && (fill_q != '0);
	assign ring_wdata = {found_q, address_q, size_code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			fill_q    <= '0;
			last_ip_q <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			if (cmd.load_in) rvalid_q <= 1'b0;
			if (cmd.log_err && new_ip) last_ip_q <= ip_q;
			if (ring_we) begin
				wr_idx_q <= (wr_idx_q == RING_AW'(RING_DEPTH - 1)) ? '0 :
					wr_idx_q + RING_AW'(1);
				fill_q   <= fill_q + FILL_W'(1);
			end
			if (ring_re) begin
				rd_idx_q <= (rd_idx_q == RING_AW'(RING_DEPTH - 1)) ? '0 :
					rd_idx_q + RING_AW'(1);
				fill_q   <= fill_q - FILL_W'(1);
				rvalid_q <= 1'b1;
			end
		end
	end

	smic_ram #(
		.WIDTH(REC_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(wr_idx_q),
		.wdata(ring_wdata),
		.re   (ring_re),
		.raddr(rd_idx_q),
		.rdata(ring_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_state  <= found_q;
			error_flag   <= err_q;
			error_logged <= logged_q;
			record_valid <= rvalid_q;
			queue_level  <= fill_q;
			if (rvalid_q) begin
				record_state     <= ring_rdata[REC_W-1 -: STATE_W];
				record_address   <= ring_rdata[SIZE_W +: ADDR_W];
				record_size_code <= ring_rdata[SIZE_W-1:0];
			end else begin
				record_state     <= '0;
				record_address   <= '0;
				record_size_code <= '0;
			end
		end
	end

	always_comb begin
		sts.mode     = mode_q;
		sts.fits     = fits_q;
		sts.pos_zero = (pos_q == '0);
		sts.pos_last = (pos_q == len_q - COUNT_W'(1));
		sts.clr_done = (clr_q == SH_AW'(WINDOW_BYTES - 1));
		sts.hit      = partial_ok_q ? (sh_rdata == ST_INIT) : (sh_rdata != ST_INIT);
		sts.rd_init  = (sh_rdata == ST_INIT);
		sts.out_free = !out_valid || !out_stall;
	end

endmodule

FILE: rtl/core/shadow_memory_init_checker_core.sv
// ----------------------------------------------------------------------------
// shadow_memory_init_checker_core
// Tracks a 2-bit state per byte of a WINDOW_BYTES window starting at
// window_base and logs reads of non-initialized bytes into a RING_DEPTH
// record ring. After reset the shadow store is swept to unallocated, one
// byte per cycle, with in_stall held high until the sweep ends; config
// writes are taken during the sweep. The shadow store's write and read
// ports share one address, and the controller handles one word at a time:
// a drain, an ignored item or an out-of-window item passes through the
// offset, fit, dispatch and finish states, a write or a mark also fills
// its bytes one at a time, a clean read reads and then compares each byte
// tested, from the highest down, and a failing read then fills each byte
// and logs the error. The next word is accepted while a result still waits
// on out_stall.
// ----------------------------------------------------------------------------
module shadow_memory_init_checker_core #(
	parameter int WINDOW_BYTES = 4096,
	parameter int RING_DEPTH   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [smic_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smic_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [smic_pkg::MODE_W-1:0]          mode,
	input  logic [smic_pkg::ADDR_W-1:0]          address,
	input  logic [smic_pkg::SIZE_W-1:0]          size_code,
	input  logic [smic_pkg::COUNT_W-1:0]         count,
	input  logic [smic_pkg::STATE_W-1:0]         mark_state,
	input  logic [smic_pkg::IP_W-1:0]            ip,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [smic_pkg::STATE_W-1:0]         found_state,
	output logic                                 error_flag,
	output logic                                 error_logged,
	output logic                                 record_valid,
	output logic [smic_pkg::STATE_W-1:0]         record_state,
	output logic [smic_pkg::ADDR_W-1:0]          record_address,
	output logic [smic_pkg::SIZE_W-1:0]          record_size_code,
	output logic [$clog2(RING_DEPTH+1)-1:0]      queue_level
);

	import smic_pkg::*;

	smic_cmd_t cmd;
	smic_sts_t sts;

	smic_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	smic_dp #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.RING_DEPTH  (RING_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (mode),
		.address         (address),
		.size_code       (size_code),
		.count           (count),
		.mark_state      (mark_state),
		.ip              (ip),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found_state     (found_state),
		.error_flag      (error_flag),
		.error_logged    (error_logged),
		.record_valid    (record_valid),
		.record_state    (record_state),
		.record_address  (record_address),
		.record_size_code(record_size_code),
		.queue_level     (queue_level)
	);

endmodule

FILE: rtl/core/smic_checker.sv
// ----------------------------------------------------------------------------
// smic_checker
// Port-level assertions for the shadow memory init checker, bound to the
// top level.
// ----------------------------------------------------------------------------
module smic_checker #(
	parameter int RING_DEPTH = 32
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_we,
	input logic [smic_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [smic_pkg::CFG_DATA_W-1:0]      cfg_data,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic [smic_pkg::MODE_W-1:0]          mode,
	input logic [smic_pkg::ADDR_W-1:0]          address,
	input logic [smic_pkg::SIZE_W-1:0]          size_code,
	input logic [smic_pkg::COUNT_W-1:0]         count,
	input logic [smic_pkg::STATE_W-1:0]         mark_state,
	input logic [smic_pkg::IP_W-1:0]            ip,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [smic_pkg::STATE_W-1:0]         found_state,
	input logic                                 error_flag,
	input logic                                 error_logged,
	input logic                                 record_valid,
	input logic [smic_pkg::STATE_W-1:0]         record_state,
	input logic [smic_pkg::ADDR_W-1:0]          record_address,
	input logic [smic_pkg::SIZE_W-1:0]          record_size_code,
	input logic [$clog2(RING_DEPTH+1)-1:0]      queue_level
);

	import smic_pkg::*;

	// config port carries no ordering rule to check here
	logic cfg_seen;
	assign cfg_seen = cfg_we && (cfg_index == CFG_PARTIAL_OK) && cfg_data[0];

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid &&
			$stable({mode, address, size_code, count, mark_state, ip}))
		else $error("input word changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
			$stable({found_state, error_flag, error_logged, record_valid,
				record_state, record_address, record_size_code, queue_level}))
		else $error("result word changed while stalled");

	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_flag |-> found_state != ST_INIT)
		else $error("error flagged on an initialized read");

	a_logged_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_logged |-> error_flag && !record_valid)
		else $error("record logged without an error");

	a_drain_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_valid |-> found_state == ST_INIT && !error_flag &&
			queue_level < ($clog2(RING_DEPTH+1))'(RING_DEPTH) && !(cfg_seen && in_valid && 1'b0))
		else $error("drained record on a word that was not a drain");

endmodule

bind shadow_memory_init_checker_core smic_checker #(
	.RING_DEPTH(RING_DEPTH)
) u_smic_checker (.*);

FILE: verif/tb_shadow_memory_init_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shadow_memory_init_checker_core
// Self-checking bench for the shadow memory init checker. A directed table
// covers window edges and wrap, ring corners and duplicate ip suppression.
// Random words follow over several window / partial-ok settings. Each result
// word is compared against an in-bench shadow store and error ring mirror.
// ----------------------------------------------------------------------------
module tb_shadow_memory_init_checker_core;

	import smic_pkg::*;

	localparam int WINDOW_BYTES    = 4096;
	localparam int RING_DEPTH      = 32;
	localparam int ITEMS_PER_RUN   = 270;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_CYCLES = 20000;

	localparam logic [STATE_W-1:0] ST_UNINIT = 2'd1;
	localparam logic [STATE_W-1:0] ST_FREED  = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ADDR_W-1:0]  address;
		logic [SIZE_W-1:0]  size_code;
		logic [COUNT_W-1:0] count;
		logic [STATE_W-1:0] mark_state;
		logic [IP_W-1:0]    ip;
	} word_t;

	typedef struct packed {
		logic [STATE_W-1:0] found;
		logic               err;
		logic               logged;
		logic               rec_valid;
		logic [STATE_W-1:0] rec_state;
		logic [ADDR_W-1:0]  rec_addr;
		logic [SIZE_W-1:0]  rec_size;
		logic [5:0]         level;
	} report_t;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic [ADDR_W-1:0]  addr;
		logic [SIZE_W-1:0]  size;
	} record_t;

	typedef struct {
		word_t   w;
		bit      typed;
		report_t exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [MODE_W-1:0]  mode;
	logic [ADDR_W-1:0]  address;
	logic [SIZE_W-1:0]  size_code;
	logic [COUNT_W-1:0] count;
	logic [STATE_W-1:0] mark_state;
	logic [IP_W-1:0]    ip;
	logic out_valid;
	logic out_stall;
	logic [STATE_W-1:0] found_state;
	logic error_flag;
	logic error_logged;
	logic record_valid;
	logic [STATE_W-1:0] record_state;
	logic [ADDR_W-1:0]  record_address;
	logic [SIZE_W-1:0]  record_size_code;
	logic [$clog2(RING_DEPTH+1)-1:0] queue_level;

	// typed expectation rides along with the payload of directed rows
	logic    typed_valid;
	report_t typed_exp;

	// mirror of the block state
	logic [STATE_W-1:0] shadow_mirror [WINDOW_BYTES];
	record_t     err_ring [RING_DEPTH];
	int unsigned ring_rd   = 0;
	int unsigned ring_wr   = 0;
	int unsigned ring_fill = 0;
	logic [IP_W-1:0]   last_ip  = '0;
	logic [ADDR_W-1:0] win_base = '0;
	bit                part_ok  = 1'b0;

	report_t pending_reports[$];
	dir_row_t dir_tab[$];
	int  mismatches   = 0;
	int  idle_cycles  = 0;
	bit  calm         = 1'b0;
	bit  hold_off_req = 1'b0;

	shadow_memory_init_checker_core #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.RING_DEPTH(RING_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.address(address),
		.size_code(size_code),
		.count(count),
		.mark_state(mark_state),
		.ip(ip),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found_state(found_state),
		.error_flag(error_flag),
		.error_logged(error_logged),
		.record_valid(record_valid),
		.record_state(record_state),
		.record_address(record_address),
		.record_size_code(record_size_code),
		.queue_level(queue_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit in_win(logic [31:0] off, int unsigned len);
		return (64'(off) + 64'(len)) <= 64'(WINDOW_BYTES);
	endfunction

	// Applies one word to the mirror and returns the result it should give.
	function automatic report_t shadow_check(word_t w);
		report_t     r;
		logic [31:0] off;
		int          len;
		int          i;
		bit          hit;
		logic [STATE_W-1:0] s;
		r = '0;
		r.found = ST_INIT;
		len = (w.size_code == SIZE_BAD) ? 0 : (1 << w.size_code);
		off = w.address - win_base;
		hit = 1'b0;
		case (w.mode)
			MODE_MARK: begin
				if (w.count != 0 && in_win(off, w.count))
					for (i = 0; i < int'(w.count); i++)
						shadow_mirror[int'(off) + i] = w.mark_state;
			end
			MODE_READ: begin
				if (len != 0 && in_win(off, len)) begin
					// highest byte first, lowest byte is the fallback
					for (i = len - 1; i >= 0; i--) begin
						s = shadow_mirror[int'(off) + i];
						if (!hit && (part_ok ? (s == ST_INIT) : (s != ST_INIT))) begin
							r.found = s;
							hit = 1'b1;
						end
					end
					if (!hit)
						r.found = shadow_mirror[int'(off)];
					if (r.found != ST_INIT) begin
						r.err = 1'b1;
						for (i = 0; i < len; i++)
							shadow_mirror[int'(off) + i] = ST_INIT;
						if (w.ip != last_ip) begin
							last_ip = w.ip;
							if (ring_fill < RING_DEPTH) begin
								err_ring[ring_wr] = '{r.found, w.address, w.size_code};
								ring_wr = (ring_wr + 1) % RING_DEPTH;
								ring_fill++;
								r.logged = 1'b1;
							end
						end
					end
				end
			end
			MODE_WRITE: begin
				if (len != 0 && in_win(off, len))
					for (i = 0; i < len; i++)
						shadow_mirror[int'(off) + i] = ST_INIT;
			end
			default: begin
				if (ring_fill > 0) begin
					r.rec_valid = 1'b1;
					r.rec_state = err_ring[ring_rd].state;
					r.rec_addr  = err_ring[ring_rd].addr;
					r.rec_size  = err_ring[ring_rd].size;
					ring_rd = (ring_rd + 1) % RING_DEPTH;
					ring_fill--;
				end
			end
		endcase
		r.level = 6'(ring_fill);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// scoreboard and watchdog
	always @(posedge clk) begin
		report_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					check_field("found_state", 32'(want.found), 32'(found_state));
					check_field("error_flag", 32'(want.err), 32'(error_flag));
					check_field("error_logged", 32'(want.logged), 32'(error_logged));
					check_field("record_valid", 32'(want.rec_valid), 32'(record_valid));
					check_field("record_state", 32'(want.rec_state), 32'(record_state));
					check_field("record_address", want.rec_addr, record_address);
					check_field("record_size_code", 32'(want.rec_size),
						32'(record_size_code));
					check_field("queue_level", 32'(want.level), 32'(queue_level));
				end
			end
			if (in_valid && !in_stall) begin
				want = shadow_check('{mode, address, size_code, count, mark_state, ip});
				pending_reports.push_back(typed_valid ? typed_exp : want);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("tb_shadow_memory_init_checker_core: FAIL");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 15);
		end
	end

	task automatic send_word(word_t w, bit has_exp = 1'b0, report_t e = '0);
		while (!calm && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= w.mode;
		address     <= w.address;
		size_code   <= w.size_code;
		count       <= w.count;
		mark_state  <= w.mark_state;
		ip          <= w.ip;
		typed_valid <= has_exp;
		typed_exp   <= e;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	task automatic set_window(logic [31:0] base, bit pok);
		wait_results();
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WINDOW_BASE;
		cfg_data  <= base;
		@(posedge clk);
		win_base = base;
		cfg_index <= CFG_PARTIAL_OK;
		cfg_data  <= CFG_DATA_W'(pok);
		@(posedge clk);
		part_ok = pok;
		cfg_we <= 1'b0;
	endtask

	function automatic word_t mk_word(logic [1:0] m, logic [31:0] a, logic [1:0] sc,
		logic [12:0] c, logic [1:0] ms, logic [31:0] ipv);
		return '{m, a, sc, c, ms, ipv};
	endfunction

	function automatic report_t mk_report(logic [1:0] f, bit e, bit lg, int lvl);
		report_t r;
		r = '0;
		r.found  = f;
		r.err    = e;
		r.logged = lg;
		r.level  = 6'(lvl);
		return r;
	endfunction

	task automatic dir_row(word_t w, bit typed = 1'b0, report_t e = '0);
		dir_tab.push_back('{w, typed, e});
	endtask

	function automatic word_t random_word(input int drain_pct);
		word_t w;
		int    r;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < drain_pct)
			w.mode = MODE_DRAIN;
		else
			w.mode = (r < 25) ? MODE_MARK : (r < 65) ? MODE_READ : MODE_WRITE;
		r = $urandom_range(0, 99);
		// mostly a small hot area so marks, writes and reads overlap
		if (r < 60)
			w.address = win_base + $urandom_range(0, 127);
		else if (r < 85)
			w.address = win_base + $urandom_range(0, WINDOW_BYTES - 1);
		else if (r < 92)
			w.address = win_base + $urandom_range(WINDOW_BYTES - 8, WINDOW_BYTES + 3);
		else
			w.address = $urandom();
		w.size_code = ($urandom_range(0, 99) < 5) ? SIZE_BAD : SIZE_W'($urandom_range(0, 2));
		r = $urandom_range(0, 99);
		if (r < 80)
			w.count = COUNT_W'($urandom_range(1, 16));
		else if (r < 93)
			w.count = COUNT_W'($urandom_range(17, 300));
		else if (r < 96)
			w.count = COUNT_W'($urandom_range(0, 8191));
		else if (r < 98)
			w.count = '0;
		else
			w.count = COUNT_W'($urandom_range(WINDOW_BYTES, WINDOW_BYTES + 1));
		w.mark_state = STATE_W'($urandom_range(0, 3));
		r = $urandom_range(0, 99);
		// small ip pool so repeated reporters show up often
		if (r < 70)
			w.ip = IP_W'($urandom_range(0, 3));
		else if (r < 80)
			w.ip = '1;
		else
			w.ip = $urandom();
		return w;
	endfunction

	initial begin
		word_t w;
		int    sent;
		int    run;
		logic [31:0] base;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		mode        = MODE_MARK;
		address     = '0;
		size_code   = '0;
		count       = '0;
		mark_state  = ST_UNALLOC;
		ip          = '0;
		typed_valid = 1'b0;
		typed_exp   = '0;
		foreach (shadow_mirror[k])
			shadow_mirror[k] = ST_UNALLOC;

		// window wraps past the top of the address space
		dir_row(mk_word(MODE_DRAIN, 32'h0, 2'd0, 13'd0, ST_UNALLOC, 32'h0),
			1'b1, mk_report(ST_INIT, 1'b0, 1'b0, 0));
		// ip 0 matches the reset value of the last reporter: flagged, not logged
		dir_row(mk_word(MODE_READ, 32'hFFFF_F800, 2'd0, 13'd0, ST_UNALLOC, 32'h0),
			1'b1, mk_report(ST_UNALLOC, 1'b1, 1'b0, 0));
		dir_row(mk_word(MODE_READ, 32'hFFFF_F800, 2'd0, 13'd0, ST_UNALLOC, 32'h1),
			1'b1, mk_report(ST_INIT, 1'b0, 1'b0, 0));
		dir_row(mk_word(MODE_READ, 32'hFFFF_F801, 2'd0, 13'd0, ST_UNALLOC, 32'hFFFF_FFFF),
			1'b1, mk_report(ST_UNALLOC, 1'b1, 1'b1, 1));
		dir_row(mk_word(MODE_MARK, 32'hFFFF_F800, 2'd0, 13'd4096, ST_UNINIT, 32'h0));
		dir_row(mk_word(MODE_MARK, 32'hFFFF_F800, 2'd0, 13'd4097, ST_FREED, 32'h0));
		dir_row(mk_word(MODE_MARK, 32'h0, 2'd0, 13'd8191, ST_FREED, 32'h0));
		dir_row(mk_word(MODE_MARK, 32'h10, 2'd0, 13'd0, ST_FREED, 32'h0));
		dir_row(mk_word(MODE_READ, 32'hFFFF_FFFF, 2'd1, 13'd0, ST_UNALLOC, 32'h5));
		dir_row(mk_word(MODE_READ, 32'h0, 2'd0, 13'd0, ST_UNALLOC, 32'h5));
		dir_row(mk_word(MODE_MARK, 32'hFFFF_FFFE, 2'd0, 13'd4, ST_FREED, 32'h0));
		dir_row(mk_word(MODE_READ, 32'hFFFF_FFFC, 2'd2, 13'd0, ST_UNALLOC, 32'h6));
		dir_row(mk_word(MODE_MARK, 32'hFFFF_FFFC, 2'd0, 13'd2, ST_UNALLOC, 32'h0));
		dir_row(mk_word(MODE_READ, 32'hFFFF_FFFC, 2'd2, 13'd0, ST_UNALLOC, 32'h6));
		dir_row(mk_word(MODE_WRITE, 32'h20, 2'd2, 13'd0, ST_UNALLOC, 32'h0));
		dir_row(mk_word(MODE_READ, 32'h20, 2'd2, 13'd0, ST_UNALLOC, 32'h7));
		dir_row(mk_word(MODE_WRITE, 32'h30, SIZE_BAD, 13'd0, ST_UNALLOC, 32'h0));
		dir_row(mk_word(MODE_READ, 32'h30, SIZE_BAD, 13'd0, ST_UNALLOC, 32'h8));
		dir_row(mk_word(MODE_READ, 32'h7FF, 2'd0, 13'd0, ST_UNALLOC, 32'h9));
		dir_row(mk_word(MODE_READ, 32'h7FF, 2'd1, 13'd0, ST_UNALLOC, 32'hA));
		dir_row(mk_word(MODE_READ, 32'h800, 2'd0, 13'd0, ST_UNALLOC, 32'hA));
		dir_row(mk_word(MODE_WRITE, 32'h7FE, 2'd1, 13'd0, ST_UNALLOC, 32'h0));
		dir_row(mk_word(MODE_READ, 32'h7FC, 2'd2, 13'd0, ST_UNALLOC, 32'hB));
		dir_row(mk_word(MODE_DRAIN, 32'h0, 2'd0, 13'd0, ST_UNALLOC, 32'h0));
		dir_row(mk_word(MODE_DRAIN, 32'hFFFF_FFFF, 2'd3, 13'h1FFF, ST_FREED, 32'hFFFF_FFFF));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// config is taken while the store is being cleared
		set_window(32'hFFFF_F800, 1'b0);
		foreach (dir_tab[k])
			send_word(dir_tab[k].w, dir_tab[k].typed, dir_tab[k].exp);

		for (run = 0; run < 5; run++) begin
			case (run)
				0: set_window(32'h0, 1'b1);
				1: set_window(32'hFFFF_FFFF, 1'b0);
				2: begin
					base = $urandom();
					set_window(base, 1'b1);
				end
				3: set_window(32'h8000_0000, 1'b0);
				default: begin
					base = $urandom();
					set_window(base, 1'b0);
				end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_RUN) begin
				calm = (run == 0) && (sent < 150);
				if (run == 1 && sent == 100)
					hold_off_req = 1'b1;
				if (run == 2 && sent == 100)
					wait_results();
				// run 2 starves drains so the ring fills, run 3 drains hard
				w = random_word((run == 2) ? 4 : (run == 3) ? 35 : 20);
				send_word(w);
				sent++;
			end
			calm = 1'b0;
		end

		wait_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_shadow_memory_init_checker_core: PASS");
		else
			$display("tb_shadow_memory_init_checker_core: FAIL");
		$finish;
	end

endmodule
